// ----- hdl/register_vm_instruction_executor_macros.svh -----
// ---------------------------------------------------------------------------
// Register VM executor assertion macros
// Shared concurrent assertion wrappers, removable with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef REGISTER_VM_INSTRUCTION_EXECUTOR_MACROS_SVH
`define REGISTER_VM_INSTRUCTION_EXECUTOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RVM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RVM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RVM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RVM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/rvm_pkg.sv -----
// ---------------------------------------------------------------------------
// Register VM package
// Opcodes, error codes, sequencer states and widths.
// ---------------------------------------------------------------------------
package rvm_pkg;
  localparam int unsigned WORD_W = 64;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_HALT = 5'd1, OP_LOAD = 5'd2, OP_ADD = 5'd3, OP_SUB = 5'd4,
    OP_EQ = 5'd5, OP_GT = 5'd6, OP_LT = 5'd7, OP_COPY = 5'd8, OP_JMP = 5'd9,
    OP_JMPF = 5'd10, OP_JMPT = 5'd11, OP_PNUM = 5'd12, OP_PCHAR = 5'd13,
    OP_INC = 5'd14, OP_DEC = 5'd15, OP_PUSH = 5'd16, OP_POP = 5'd17,
    OP_DIV = 5'd18, OP_MOD = 5'd19
  } opcode_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_INVALID = 2'd1, ERR_UNDER = 2'd2, ERR_OVER = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_WRITE, ST_OUT
  } state_t;

  localparam logic [WORD_W-1:0] CHAR_MASK = 64'hFF;

  typedef struct packed {
    logic start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] rem;
  } div_rsp_t;
endpackage

// ----- hdl/rvm_divider.sv -----
// ---------------------------------------------------------------------------
// Register VM divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`include "register_vm_instruction_executor_macros.svh"
module rvm_divider (
  input  logic             clk,
  input  logic             rst_n,
  input  rvm_pkg::div_req_t req,
  output rvm_pkg::div_rsp_t rsp
);
  localparam int unsigned W = rvm_pkg::WORD_W;

  logic         busy_r, busy_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [W-1:0] q_r, q_nxt;
  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] dsr_r, dsr_nxt;
  logic         done_r, done_nxt;
  logic [W:0]   trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, q_r[W-1]} - {1'b0, dsr_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'(W);
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], q_r[W-1]};
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

  `RVM_ASSERT_NXT(a_done_ends_busy, clk, rst_n, busy_r && cnt_r == 7'd1 && !req.start, done_r)
  `RVM_ASSERT_IMP(a_cnt_bound, clk, rst_n, busy_r, cnt_r != 7'd0)
  `RVM_ASSERT_IMP(a_done_idle, clk, rst_n, done_r, !busy_r)
endmodule

// ----- hdl/register_vm_instruction_executor.sv -----
// ---------------------------------------------------------------------------
// Register VM instruction executor
// Executes one decoded instruction per item on a register file and stack.
// ---------------------------------------------------------------------------
// Input item: one decoded instruction on in_tvalid/in_tready/in_tdata.
// Result item: one per instruction on out_tvalid/out_tready/out_tdata.
// Items are taken one at a time: a new instruction is accepted only in the
// idle state. Most opcodes then pass the read, execute, write and output
// states; push and pop the same, pop taking its value from the registered
// stack memory read. Divide and modulo by a nonzero divisor add a divide
// state that waits on the shared bit-serial divider.
// in_tready is high only while idle. A result waits in the output register
// until taken; a stalled receiver holds the block.
// Reset clears the register file, stack depth and sequencer. Stack memory
// contents are undefined until pushed and need no clearing.
// ---------------------------------------------------------------------------
`include "register_vm_instruction_executor_macros.svh"
module register_vm_instruction_executor #(
  parameter int unsigned NUM_REGS    = 16,
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // kind[4:0], dest_index[8:5], left_index[12:9], right_index[16:13],
  // immediate[80:17], zero pad
  input  logic [87:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // jump_taken[0], jump_target[64:1], halt[65], print_valid[66],
  // print_is_char[67], print_value[131:68], error_code[133:132], zero pad
  output logic [135:0] out_tdata
);
  localparam int unsigned W   = rvm_pkg::WORD_W;
  localparam int unsigned RW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned SW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW  = $clog2(STACK_DEPTH + 1);

  rvm_pkg::state_t state_r, state_nxt;
  logic [4:0]    op_r;
  logic [RW-1:0] d_r, l_r, r_r;
  logic [W-1:0]  imm_r;
  logic [W-1:0]  dv_r, lv_r, rv_r;
  logic [W-1:0]  regs_r [NUM_REGS];
  logic [W-1:0]  stack_mem [STACK_DEPTH];
  logic [W-1:0]  stk_rd_r;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [W-1:0]  wval_r, wval_nxt;
  logic          wen_r, wen_nxt;
  logic          ovld_r;
  logic [135:0]  odata_r, odata_nxt;
  logic          jt, hl, pv, pc;
  logic [W-1:0]  pval;
  rvm_pkg::err_t err;
  rvm_pkg::div_req_t dreq;
  rvm_pkg::div_rsp_t drsp;
  logic [4:0]    in_kind;
  logic [3:0]    in_d, in_l, in_r;

  // wrap a 4-bit index into the register file by repeated subtraction
  function automatic logic [RW-1:0] reg_sel(logic [3:0] idx);
    logic [8:0] v;
    v = {5'd0, idx};
    for (int k = 0; k < 8; k++) begin
      if (v >= 9'(NUM_REGS)) v = v - 9'(NUM_REGS);
    end
    return RW'(v);
  endfunction

  assign in_kind = in_tdata[4:0];
  assign in_d = in_tdata[8:5];
  assign in_l = in_tdata[12:9];
  assign in_r = in_tdata[16:13];
  assign in_tready = (state_r == rvm_pkg::ST_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata = odata_r;

  rvm_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rvm_pkg::ST_IDLE;
      depth_r <= '0;
      ovld_r  <= 1'b0;
      wen_r   <= 1'b0;
      for (int i = 0; i < int'(NUM_REGS); i++) regs_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      wen_r   <= wen_nxt;
      if (state_r == rvm_pkg::ST_WRITE && wen_r) regs_r[d_r] <= wval_r;
      if (state_r == rvm_pkg::ST_WRITE) ovld_r <= 1'b1;
      else if (ovld_r && out_tready) ovld_r <= 1'b0;
    end
    wval_r  <= wval_nxt;
    odata_r <= odata_nxt;
    if (in_tvalid && in_tready) begin
      op_r  <= in_kind;
      d_r   <= reg_sel(in_d);
      l_r   <= reg_sel(in_l);
      r_r   <= reg_sel(in_r);
      imm_r <= in_tdata[80:17];
    end
    if (state_r == rvm_pkg::ST_READ) begin
      dv_r <= regs_r[d_r];
      lv_r <= regs_r[l_r];
      rv_r <= regs_r[r_r];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rvm_pkg::ST_EXEC && op_r == rvm_pkg::OP_PUSH && depth_r < DW'(STACK_DEPTH))
      stack_mem[depth_r[SW-1:0]] <= dv_r;
    stk_rd_r <= stack_mem[SW'(depth_r - DW'(1))];
  end

  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    wen_nxt   = wen_r;
    wval_nxt  = wval_r;
    odata_nxt = odata_r;
    dreq.start    = 1'b0;
    dreq.dividend = dv_r;
    dreq.divisor  = lv_r;
    jt = 1'b0; hl = 1'b0; pv = 1'b0; pc = 1'b0; pval = '0;
    err = rvm_pkg::ERR_NONE;
    unique case (state_r)
      rvm_pkg::ST_IDLE: if (in_tvalid) state_nxt = rvm_pkg::ST_READ;
      rvm_pkg::ST_READ: state_nxt = rvm_pkg::ST_EXEC;
      rvm_pkg::ST_EXEC: begin
        wen_nxt = 1'b0;
        state_nxt = rvm_pkg::ST_WRITE;
        case (op_r)
          rvm_pkg::OP_NOP: ;
          rvm_pkg::OP_HALT: hl = 1'b1;
          rvm_pkg::OP_LOAD: begin wen_nxt = 1'b1; wval_nxt = imm_r; end
          rvm_pkg::OP_ADD: begin wen_nxt = 1'b1; wval_nxt = dv_r + lv_r; end
          rvm_pkg::OP_SUB: begin wen_nxt = 1'b1; wval_nxt = dv_r - lv_r; end
          rvm_pkg::OP_EQ: begin wen_nxt = 1'b1; wval_nxt = W'(lv_r == rv_r); end
          rvm_pkg::OP_GT: begin wen_nxt = 1'b1; wval_nxt = W'(lv_r > rv_r); end
          rvm_pkg::OP_LT: begin wen_nxt = 1'b1; wval_nxt = W'(lv_r < rv_r); end
          rvm_pkg::OP_COPY: begin wen_nxt = 1'b1; wval_nxt = lv_r; end
          rvm_pkg::OP_JMP: jt = 1'b1;
          rvm_pkg::OP_JMPF: jt = (dv_r == '0);
          rvm_pkg::OP_JMPT: jt = (dv_r != '0);
          rvm_pkg::OP_PNUM: begin pv = 1'b1; pval = dv_r; end
          rvm_pkg::OP_PCHAR: begin pv = 1'b1; pc = 1'b1; pval = dv_r & rvm_pkg::CHAR_MASK; end
          rvm_pkg::OP_INC: begin wen_nxt = 1'b1; wval_nxt = dv_r + W'(1); end
          rvm_pkg::OP_DEC: begin wen_nxt = 1'b1; wval_nxt = dv_r - W'(1); end
          rvm_pkg::OP_PUSH: begin
            if (depth_r >= DW'(STACK_DEPTH)) err = rvm_pkg::ERR_OVER;
            else depth_nxt = depth_r + DW'(1);
          end
          rvm_pkg::OP_POP: begin
            if (depth_r == '0) err = rvm_pkg::ERR_UNDER;
            else begin
              depth_nxt = depth_r - DW'(1);
              wen_nxt = 1'b1;
              wval_nxt = stk_rd_r;
            end
          end
          rvm_pkg::OP_DIV, rvm_pkg::OP_MOD: begin
            if (lv_r == '0) begin
              wen_nxt = 1'b1;
              wval_nxt = (op_r == rvm_pkg::OP_DIV) ? '1 : dv_r;
            end else begin
              dreq.start = 1'b1;
              state_nxt = rvm_pkg::ST_DIV;
            end
          end
          default: err = rvm_pkg::ERR_INVALID;
        endcase
        odata_nxt = {2'b00, err, pval, pc, pv, hl, (jt ? imm_r : W'(0)), jt};
      end
      rvm_pkg::ST_DIV: if (drsp.done) begin
        wen_nxt = 1'b1;
        wval_nxt = (op_r == rvm_pkg::OP_DIV) ? drsp.quot : drsp.rem;
        state_nxt = rvm_pkg::ST_WRITE;
      end
      rvm_pkg::ST_WRITE: state_nxt = rvm_pkg::ST_OUT;
      rvm_pkg::ST_OUT: if (out_tready) state_nxt = rvm_pkg::ST_IDLE;
      default: state_nxt = rvm_pkg::ST_IDLE;
    endcase
  end

  `RVM_ASSERT_IMP(a_out_only_in_out, clk, rst_n, ovld_r, state_r == rvm_pkg::ST_OUT)
  `RVM_ASSERT_IMP(a_depth_bound, clk, rst_n, 1'b1, depth_r <= DW'(STACK_DEPTH))
  `RVM_ASSERT_NXT(a_accept_reads, clk, rst_n, in_tvalid && in_tready, state_r == rvm_pkg::ST_READ)
  `RVM_ASSERT_NXT(a_depth_step, clk, rst_n, state_r != rvm_pkg::ST_EXEC, $stable(depth_r))
endmodule

// ----- sim/tb_register_vm_instruction_executor.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Register VM instruction executor testbench
// Drives decoded instructions through the input stream, tracks the register
// file and stack in a local machine model and checks every result item
// field by field. A directed table comes first, then a stack fill and drain, then random programs.
// ---------------------------------------------------------------------------
module tb_register_vm_instruction_executor;
  localparam int NREG = 16;
  localparam int SDEPTH = 64;
  localparam int RANDOM_ITEMS = 1590;
  localparam longint CYCLE_LIMIT = 1200000;

  typedef struct packed {
    logic [63:0] immediate;
    logic [3:0]  right_index;
    logic [3:0]  left_index;
    logic [3:0]  dest_index;
    logic [4:0]  kind;
  } instr_t;

  typedef struct packed {
    rvm_pkg::err_t error_code;
    logic [63:0] print_value;
    logic        print_is_char;
    logic        print_valid;
    logic        halt;
    logic [63:0] jump_target;
    logic        jump_taken;
  } outcome_t;

  typedef struct {
    instr_t   ins;
    logic     fixed;
    outcome_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [87:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [135:0] out_tdata;

  always #4 clk = ~clk;

  register_vm_instruction_executor DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  logic [63:0] regs [NREG];
  logic [63:0] stack_mem [SDEPTH];
  int depth;
  outcome_t pending_results[$];
  row_t table_rows[$];
  int mismatches = 0;
  int results_seen = 0;
  int errors_seen = 0;
  int sender_idle = 0;
  int receiver_idle = 0;
  longint cycles = 0;

  function automatic outcome_t execute_instr(instr_t ins);
    outcome_t o;
    logic [63:0] dv, lv, rv;
    o = '0;
    dv = regs[ins.dest_index];
    lv = regs[ins.left_index];
    rv = regs[ins.right_index];
    case (ins.kind)
      rvm_pkg::OP_NOP: ;
      rvm_pkg::OP_HALT: o.halt = 1'b1;
      rvm_pkg::OP_LOAD: regs[ins.dest_index] = ins.immediate;
      rvm_pkg::OP_ADD: regs[ins.dest_index] = dv + lv;
      rvm_pkg::OP_SUB: regs[ins.dest_index] = dv - lv;
      rvm_pkg::OP_EQ: regs[ins.dest_index] = {63'd0, lv == rv};
      rvm_pkg::OP_GT: regs[ins.dest_index] = {63'd0, lv > rv};
      rvm_pkg::OP_LT: regs[ins.dest_index] = {63'd0, lv < rv};
      rvm_pkg::OP_COPY: regs[ins.dest_index] = lv;
      rvm_pkg::OP_JMP: o.jump_taken = 1'b1;
      rvm_pkg::OP_JMPF: o.jump_taken = (dv == 0);
      rvm_pkg::OP_JMPT: o.jump_taken = (dv != 0);
      rvm_pkg::OP_PNUM: begin
        o.print_valid = 1'b1;
        o.print_value = dv;
      end
      rvm_pkg::OP_PCHAR: begin
        o.print_valid = 1'b1;
        o.print_is_char = 1'b1;
        o.print_value = dv & 64'hFF;
      end
      rvm_pkg::OP_INC: regs[ins.dest_index] = dv + 64'd1;
      rvm_pkg::OP_DEC: regs[ins.dest_index] = dv - 64'd1;
      rvm_pkg::OP_PUSH: begin
        if (depth >= SDEPTH) o.error_code = rvm_pkg::ERR_OVER;
        else begin
          stack_mem[depth] = dv;
          depth++;
        end
      end
      rvm_pkg::OP_POP: begin
        if (depth == 0) o.error_code = rvm_pkg::ERR_UNDER;
        else begin
          depth--;
          regs[ins.dest_index] = stack_mem[depth];
        end
      end
      rvm_pkg::OP_DIV: regs[ins.dest_index] = (lv == 0) ? '1 : dv / lv;
      rvm_pkg::OP_MOD: regs[ins.dest_index] = (lv == 0) ? dv : dv % lv;
      default: o.error_code = rvm_pkg::ERR_INVALID;
    endcase
    if (o.jump_taken) o.jump_target = ins.immediate;
    return o;
  endfunction

  function automatic instr_t mk(int k, int d, int l, int r, logic [63:0] imm);
    instr_t i;
    i.kind = k[4:0];
    i.dest_index = d[3:0];
    i.left_index = l[3:0];
    i.right_index = r[3:0];
    i.immediate = imm;
    return i;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = 64'($urandom_range(0, 20));
      3: v = 64'h8000_0000_0000_0000;
      default: ;
    endcase
    return v;
  endfunction

  function automatic instr_t rand_instr();
    int p;
    p = $urandom_range(0, 99);
    if (p < 5) return mk($urandom_range(20, 31), $urandom_range(0, 15),
                         $urandom_range(0, 15), $urandom_range(0, 15), rand64());
    if (p < 10) return mk($urandom_range(18, 19), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom_range(0, 15), rand64());
    if (p < 30) return mk(($urandom_range(0, 2) == 0) ? rvm_pkg::OP_POP : rvm_pkg::OP_PUSH,
                          $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15), rand64());
    if (p < 45) return mk(rvm_pkg::OP_LOAD, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15), rand64());
    return mk($urandom_range(0, 17), $urandom_range(0, 15), $urandom_range(0, 15),
              $urandom_range(0, 15), rand64());
  endfunction

  task automatic send_instr(instr_t ins);
    while (sender_idle > 0 && $urandom_range(0, 99) < sender_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, ins};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic add_row(instr_t ins, logic fixed, outcome_t want);
    row_t r;
    r.ins = ins;
    r.fixed = fixed;
    r.want = want;
    table_rows = {table_rows, r};
  endtask

  task automatic run_row(row_t r);
    outcome_t o;
    o = execute_instr(r.ins);
    if (r.fixed) o = r.want;
    pending_results = {pending_results, o};
    if (o.error_code != rvm_pkg::ERR_NONE) errors_seen++;
    send_instr(r.ins);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) out_tready <= (receiver_idle == 0) || ($urandom_range(0, 99) >= receiver_idle);
  end

  always @(posedge clk) begin
    outcome_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[133:0];
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at result %0d", results_seen);
            $display("  jump %b/%h want %b/%h", got.jump_taken, got.jump_target,
                     want.jump_taken, want.jump_target);
            $display("  halt %b want %b, print %b%b/%h want %b%b/%h", got.halt,
                     want.halt, got.print_valid, got.print_is_char, got.print_value,
                     want.print_valid, want.print_is_char, want.print_value);
            $display("  error %0d want %0d", got.error_code, want.error_code);
          end
        end
      end
    end
  end

  initial begin
    outcome_t none, w;
    int wait_cycles;
    for (int i = 0; i < NREG; i++) regs[i] = '0;
    depth = 0;
    none = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    w = none; w.print_valid = 1'b1;
    add_row(mk(rvm_pkg::OP_PNUM, 15, 0, 0, '0), 1'b1, w);
    w = none; w.error_code = rvm_pkg::ERR_UNDER;
    add_row(mk(rvm_pkg::OP_POP, 3, 0, 0, '0), 1'b1, w);
    add_row(mk(rvm_pkg::OP_NOP, 15, 15, 15, '1), 1'b1, none);
    w = none; w.halt = 1'b1;
    add_row(mk(rvm_pkg::OP_HALT, 0, 0, 0, '1), 1'b1, w);
    w = none; w.error_code = rvm_pkg::ERR_INVALID;
    add_row(mk(20, 1, 2, 3, '1), 1'b1, w);
    add_row(mk(31, 15, 15, 15, '1), 1'b1, w);
    w = none; w.jump_taken = 1'b1; w.jump_target = '1;
    add_row(mk(rvm_pkg::OP_JMP, 0, 0, 0, '1), 1'b1, w);
    add_row(mk(rvm_pkg::OP_LOAD, 1, 0, 0, '1), 1'b0, none);
    add_row(mk(rvm_pkg::OP_LOAD, 2, 0, 0, 64'd7), 1'b0, none);
    add_row(mk(rvm_pkg::OP_PCHAR, 1, 0, 0, '0), 1'b0, none);
    add_row(mk(rvm_pkg::OP_ADD, 1, 2, 0, '0), 1'b0, none);
    add_row(mk(rvm_pkg::OP_SUB, 3, 2, 0, '0), 1'b0, none);
    add_row(mk(rvm_pkg::OP_EQ, 4, 1, 2, '0), 1'b0, none);
    add_row(mk(rvm_pkg::OP_GT, 5, 3, 2, '0), 1'b0, none);
    add_row(mk(rvm_pkg::OP_LT, 6, 2, 3, '0), 1'b0, none);
    add_row(mk(rvm_pkg::OP_COPY, 7, 3, 0, '0), 1'b0, none);
    add_row(mk(rvm_pkg::OP_JMPF, 0, 0, 0, 64'h55), 1'b0, none);
    add_row(mk(rvm_pkg::OP_JMPT, 3, 0, 0, 64'hAA), 1'b0, none);
    add_row(mk(rvm_pkg::OP_INC, 15, 0, 0, '0), 1'b0, none);
    add_row(mk(rvm_pkg::OP_DEC, 0, 0, 0, '0), 1'b0, none);
    add_row(mk(rvm_pkg::OP_DIV, 7, 2, 0, '0), 1'b0, none);
    add_row(mk(rvm_pkg::OP_MOD, 3, 2, 0, '0), 1'b0, none);
    add_row(mk(rvm_pkg::OP_DIV, 2, 8, 0, '0), 1'b0, none);
    add_row(mk(rvm_pkg::OP_MOD, 3, 8, 0, '0), 1'b0, none);
    add_row(mk(rvm_pkg::OP_PUSH, 3, 0, 0, '0), 1'b0, none);
    add_row(mk(rvm_pkg::OP_POP, 9, 0, 0, '0), 1'b0, none);

    sender_idle = 29; receiver_idle = 69;
    foreach (table_rows[i]) run_row(table_rows[i]);

    // fill the stack past its top, then drain it past empty
    for (int i = 0; i < SDEPTH + 2; i++)
      run_row('{mk(rvm_pkg::OP_PUSH, i, 0, 0, '0), 1'b0, none});
    for (int i = 0; i < SDEPTH + 2; i++)
      run_row('{mk(rvm_pkg::OP_POP, i, 0, 0, '0), 1'b0, none});

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin sender_idle = 69; receiver_idle = 29; end
      if (n == 2 * RANDOM_ITEMS / 3) begin sender_idle = 0; receiver_idle = 0; end
      run_row('{rand_instr(), 1'b0, none});
    end
    in_tvalid <= 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);

    $display("ran %0d instructions incl. stack fill/drain, got %0d results, %0d errors",
             table_rows.size() + 2 * (SDEPTH + 2) + RANDOM_ITEMS, results_seen,
             errors_seen);
    $display("mismatches %0d, results left over %0d", mismatches,
             pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/rvm_pkg.sv
hdl/rvm_divider.sv
hdl/register_vm_instruction_executor.sv
sim/tb_register_vm_instruction_executor.sv
